FILE: rtl/inr_pkg.sv
// ----------------------------------------------------------------------------
// Integer n-th root package
// Shared constants and the sequencer state type for the n-th root block.
// ----------------------------------------------------------------------------
`default_nettype none

package inr_pkg;

  localparam int DATA_W              = 64;
  localparam int DEFAULT_VALUE_WIDTH = 64;
  localparam int DEFAULT_MUL_WIDTH   = 32;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SETUP,
    ST_MUL_LO,
    ST_MUL_HI,
    ST_CHECK,
    ST_FINISH
  } state_t;

endpackage

`default_nettype wire

FILE: rtl/integer_nth_root.sv
// Special cases (degree 0 or 1, radicand 0, degree of VALUE_WIDTH or more) go
// straight to the finish step; otherwise each of the (VALUE_WIDTH+1)/2 root bits
// runs a setup step and then up to degree multiplies (low half, high half, check),
// paced by the single shared multiplier, before the finish step.
// Throughput: one item at a time; in_ready is high only while idle.
// Reset clears the sequencer and the output valid; no state is kept between items.
// ----------------------------------------------------------------------------
// Integer n-th root
// Floor of the n-th root of an unsigned value, built one root bit at a time
// with an overflow-safe power test on a shared multiplier.
// ----------------------------------------------------------------------------
`default_nettype none

module integer_nth_root #(
  parameter int VALUE_WIDTH = inr_pkg::DEFAULT_VALUE_WIDTH
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [inr_pkg::DATA_W-1:0] radicand,
  input  logic [inr_pkg::DATA_W-1:0] degree,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [inr_pkg::DATA_W-1:0] root
);
  import inr_pkg::*;

  localparam int ROOT_W = (VALUE_WIDTH + 1) / 2;
  localparam int PROD_W = 2 * ROOT_W;
  localparam int FULL_W = 3 * ROOT_W;
  localparam int DEG_W  = $clog2(VALUE_WIDTH);
  localparam int BIT_W  = $clog2(ROOT_W);

  state_t state, state_next;

  logic [VALUE_WIDTH-1:0] x;
  logic [DEG_W-1:0]       deg;
  logic [DEG_W-1:0]       cnt;
  logic [ROOT_W-1:0]      r;
  logic [ROOT_W-1:0]      cand;
  logic [BIT_W-1:0]       bidx;
  logic [VALUE_WIDTH-1:0] acc;
  logic [PROD_W-1:0]      prod_lo;
  logic [VALUE_WIDTH-1:0] res;
  logic [DATA_W-1:0]      root_q;

  logic [VALUE_WIDTH-1:0] x_in;
  logic                   deg_zero, deg_one, deg_big, x_zero, special;
  logic [VALUE_WIDTH-1:0] special_val;
  logic [ROOT_W-1:0]      mul_a;
  logic [PROD_W-1:0]      mul_p;
  logic [FULL_W-1:0]      full;
  logic                   fail, bit_done, out_free;
  logic [ROOT_W-1:0]      r_new;

  assign x_in     = radicand[VALUE_WIDTH-1:0];
  assign deg_zero = (degree == '0);
  assign deg_one  = (degree == DATA_W'(1));
  assign deg_big  = (degree >= DATA_W'(VALUE_WIDTH));
  assign x_zero   = (x_in == '0);
  assign special  = deg_zero || x_zero || deg_one || deg_big;

  always_comb begin
    if (deg_zero || x_zero) begin
      special_val = '0;
    end else if (deg_one) begin
      special_val = x_in;
    end else begin
      special_val = VALUE_WIDTH'(1);
    end
  end

  assign mul_a = (state == ST_MUL_LO) ? acc[ROOT_W-1:0] : ROOT_W'(acc >> ROOT_W);

  inr_mul #(
    .WIDTH(ROOT_W)
  ) u_mul (
    .clk(clk),
    .a  (mul_a),
    .b  (cand),
    .p  (mul_p)
  );

  assign full     = (FULL_W'(mul_p) << ROOT_W) + FULL_W'(prod_lo);
  assign fail     = (full > FULL_W'(x));
  assign bit_done = fail || (cnt == DEG_W'(1));
  assign r_new    = fail ? r : cand;
  assign out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          state_next = special ? ST_FINISH : ST_SETUP;
        end
      end
      ST_SETUP:  state_next = ST_MUL_LO;
      ST_MUL_LO: state_next = ST_MUL_HI;
      ST_MUL_HI: state_next = ST_CHECK;
      ST_CHECK: begin
        if (!bit_done) begin
          state_next = ST_MUL_LO;
        end else if (bidx == '0) begin
          state_next = ST_FINISH;
        end else begin
          state_next = ST_SETUP;
        end
      end
      ST_FINISH: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready = (state == ST_IDLE);
    root     = root_q;
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          x    <= x_in;
          deg  <= degree[DEG_W-1:0];
          r    <= '0;
          bidx <= BIT_W'(ROOT_W - 1);
          res  <= special_val;
        end
      end
      ST_SETUP: begin
        cand <= r | (ROOT_W'(1) << bidx);
        acc  <= VALUE_WIDTH'(1);
        cnt  <= deg;
      end
      ST_MUL_HI: begin
        prod_lo <= mul_p;
      end
      ST_CHECK: begin
        if (bit_done) begin
          r    <= r_new;
          bidx <= bidx - BIT_W'(1);
          res  <= VALUE_WIDTH'(r_new);
        end else begin
          acc <= full[VALUE_WIDTH-1:0];
          cnt <= cnt - DEG_W'(1);
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == ST_FINISH && out_free) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_FINISH && out_free) begin
      root_q <= DATA_W'(res);
    end
  end

  a_check_count: assert property (@(posedge clk) disable iff (rst)
    (state == ST_CHECK) |-> (cnt != '0))
    else $error("Power test reached with an empty multiply count.");

  a_acc_bound: assert property (@(posedge clk) disable iff (rst)
    (state == ST_MUL_LO) |-> (acc <= x))
    else $error("Running power exceeds the radicand.");

  a_out_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> ($past(state) == ST_FINISH))
    else $error("Result raised outside the finish step.");

endmodule

`default_nettype wire

FILE: rtl/inr_mul.sv
// ----------------------------------------------------------------------------
// Integer n-th root multiplier
// Unsigned square multiplier with a registered product, shared by all multiply steps.
// ----------------------------------------------------------------------------
`default_nettype none

module inr_mul #(
  parameter int WIDTH = inr_pkg::DEFAULT_MUL_WIDTH
) (
  input  logic               clk,
  input  logic [WIDTH-1:0]   a,
  input  logic [WIDTH-1:0]   b,
  output logic [2*WIDTH-1:0] p
);
  import inr_pkg::*;

  logic [2*WIDTH-1:0] prod;

  assign prod = a * b;

  always_ff @(posedge clk) begin
    p <= prod;
  end

endmodule

`default_nettype wire
